/* sv/pcd_pkg.sv */
package pcd_pkg;

    // Field and register widths
    localparam int PIX_W = 8;   // grey pixel
    localparam int CNT_W = 7;   // frame count register
    localparam int IDX_W = 6;   // frame index

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quo;
        logic [CNT_W-1:0] rem;
    } t_div_stat;

endpackage

/* sv/pixel_cross_dissolve.sv */
// Channel   Valid         Ready         Payload
// input     i_valid       o_ready       i_pixel_first, i_pixel_second
// output    o_valid       i_ready       o_blended_pixel, o_frame_index, o_last_of_run
// config    i_cfg_valid   o_cfg_ready   i_cfg_frame_count
//
// Per pixel pair: the pair is accepted, the serial divider splits
// (second - first) by the frame count, its quotient is taken, then one
// result per cycle follows for n frames while the output is not stalled.
// A frame count of zero accepts the pair and gives no result.
// Reset (synchronous, active low) sets the frame count to 16 and empties the
// output register. A stalled output holds the run; o_ready stays low until the
// run's last transfer has been loaded into the output register.
module pixel_cross_dissolve import pcd_pkg::*; #(
    parameter int MAX_FRAMES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_frame_count,
    // pixel pairs
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel_first,
    input  logic [PIX_W-1:0] i_pixel_second,
    // blended results
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_blended_pixel,
    output logic [IDX_W-1:0] o_frame_index,
    output logic             o_last_of_run
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_frame_count, n_frame_count;
    logic [CNT_W-1:0]  r_n, n_n;       // effective frame count
    logic              r_neg, n_neg;   // second < first
    logic [PIX_W-1:0]  r_q, n_q;       // running quotient = current result
    logic [CNT_W-1:0]  r_r, n_r;       // running remainder
    logic [PIX_W-1:0]  r_qd, n_qd;     // per-frame quotient step (mod 256)
    logic [CNT_W-1:0]  r_rd, n_rd;     // per-frame remainder step
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_pix, n_out_pix;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;

    logic [CNT_W-1:0]  eff_n;
    logic [PIX_W:0]    diff;
    logic [PIX_W-1:0]  diff_abs;
    logic              div_start;
    t_div_stat         div_stat;
    logic              in_xfer;
    logic              slot_free;
    logic [CNT_W-1:0]  rem_sum;
    logic              rem_wrap;
    logic              is_last;
    logic [CNT_W-1:0]  n_minus_one;

    // Clamp the frame count, form |second - first|
    assign eff_n    = (r_frame_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                           : r_frame_count;
    assign diff     = {1'b0, i_pixel_second} - {1'b0, i_pixel_first};
    assign diff_abs = diff[PIX_W] ? ((~diff[PIX_W-1:0]) + 1'b1) : diff[PIX_W-1:0];

    assign in_xfer   = i_valid && o_ready;
    assign div_start = in_xfer && (eff_n != '0);

    pcd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (diff_abs),
        .i_divisor  (eff_n),
        .o_stat     (div_stat)
    );

    // Per-frame step: remainder add with one wrap, quotient add with carry
    assign rem_sum     = r_r + r_rd;
    assign rem_wrap    = (rem_sum >= r_n);
    assign n_minus_one = r_n - 1'b1;
    assign is_last     = ({1'b0, r_idx} == n_minus_one);
    assign slot_free   = !r_out_valid || i_ready;

    always_comb begin
        n_state       = r_state;
        n_frame_count = r_frame_count;
        n_n           = r_n;
        n_neg         = r_neg;
        n_q           = r_q;
        n_r           = r_r;
        n_qd          = r_qd;
        n_rd          = r_rd;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid;
        n_out_pix     = r_out_pix;
        n_out_idx     = r_out_idx;
        n_out_last    = r_out_last;

        if (i_cfg_valid) begin
            n_frame_count = i_cfg_frame_count;
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (div_start) begin
                    n_state = S_DIV;
                    n_n     = eff_n;
                    n_neg   = diff[PIX_W];
                    n_q     = i_pixel_first;
                    n_r     = '0;
                    n_idx   = '0;
                end
            end
            S_DIV: begin
                // floor split of the signed difference by n
                if (div_stat.done) begin
                    n_state = S_EMIT;
                    if (!r_neg) begin
                        n_qd = div_stat.quo;
                        n_rd = div_stat.rem;
                    end else if (div_stat.rem == '0) begin
                        n_qd = ~div_stat.quo + 1'b1;
                        n_rd = '0;
                    end else begin
                        n_qd = ~div_stat.quo;
                        n_rd = r_n - div_stat.rem;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_q;
                    n_out_idx   = r_idx;
                    n_out_last  = is_last;
                    n_r         = rem_wrap ? (rem_sum - r_n) : rem_sum;
                    n_q         = r_q + r_qd + {{(PIX_W-1){1'b0}}, rem_wrap};
                    n_idx       = r_idx + 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= CNT_W'(16);
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frame_count <= n_frame_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_neg      <= n_neg;
        r_q        <= n_q;
        r_r        <= n_r;
        r_qd       <= n_qd;
        r_rd       <= n_rd;
        r_idx      <= n_idx;
        r_out_pix  <= n_out_pix;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_blended_pixel = r_out_pix;
    assign o_frame_index   = r_out_idx;
    assign o_last_of_run   = r_out_last;

endmodule

/* sv/pcd_divider.sv */
// Restoring divider, one quotient bit per cycle.
// Divisor is 1..64, so the remainder always fits in CNT_W bits.
module pcd_divider import pcd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PIX_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output t_div_stat        o_stat
);

    localparam int STEP_W = $clog2(PIX_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [PIX_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_div, n_div;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // One trial subtraction per cycle
    assign trial = {r_rem, r_quo[PIX_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            n_quo = {r_quo[PIX_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(PIX_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;
    assign o_stat.rem  = r_rem;

endmodule

/* sv/pcd_checker.sv */
module pcd_checker import pcd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [PIX_W-1:0] o_blended_pixel,
    input logic [IDX_W-1:0] o_frame_index,
    input logic             o_last_of_run
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_blended_pixel)
                                   && $stable(o_frame_index) && $stable(o_last_of_run)))
        else $error("stalled result changed");

    // A run only starts at frame zero
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_frame_index == '0))
        else $error("run did not start at frame zero");

    // No new pixel pair while a run is still pending
    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> !o_ready)
        else $error("input ready in the middle of a run");

    // Output goes empty after the last transfer of a run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_of_run) |=> !o_valid)
        else $error("result after end of run");

endmodule

bind pixel_cross_dissolve pcd_checker u_pcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_blended_pixel (o_blended_pixel),
    .o_frame_index   (o_frame_index),
    .o_last_of_run   (o_last_of_run)
);

/* tb/pixel_cross_dissolve_tb.sv */
`timescale 1ns / 1ps

module pixel_cross_dissolve_tb;
    import pcd_pkg::*;

    localparam int MAX_FRAMES    = 64;
    localparam int RAND_PHASES   = 14;
    localparam int RAND_PER_PHASE = 15;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;

    // One blended result as the block should present it
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_blend_result;

    // Predicts every frame of each accepted pixel pair and checks outputs in order
    class dissolve_scoreboard;
        logic [CNT_W-1:0] frame_count;
        t_blend_result    blend_q[$];
        int               errors;

        function new();
            frame_count = 7'd16;
            errors      = 0;
        endfunction

        function void set_frames(logic [CNT_W-1:0] value);
            frame_count = value;
        endfunction

        function int pending();
            return blend_q.size();
        endfunction

        // Expand one pair into its run of cross-faded values
        function void note_pair(logic [PIX_W-1:0] first, logic [PIX_W-1:0] second);
            int unsigned   n;
            int unsigned   sum;
            t_blend_result res;
            n = frame_count;
            if (n > MAX_FRAMES) n = MAX_FRAMES;
            for (int unsigned a = 0; a < n; a++) begin
                sum      = first * (n - a) + second * a;
                res.pix  = PIX_W'(sum / n);
                res.idx  = IDX_W'(a);
                res.last = (a + 1 == n);
                blend_q  = {blend_q, res};
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic [IDX_W-1:0] idx,
                                   logic last);
            t_blend_result want;
            if (blend_q.size() == 0) begin
                $error("unexpected result: blended_pixel %0d frame_index %0d last_of_run %0d",
                       pix, idx, last);
                errors++;
                return;
            end
            want = blend_q.pop_front();
            if (pix !== want.pix) begin
                $error("blended_pixel: expected %0d, actual %0d", want.pix, pix);
                errors++;
            end
            if (idx !== want.idx) begin
                $error("frame_index: expected %0d, actual %0d", want.idx, idx);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_frame_count;
    logic             i_valid;
    logic             o_ready;
    logic [PIX_W-1:0] i_pixel_first;
    logic [PIX_W-1:0] i_pixel_second;
    logic             o_valid;
    logic             i_ready;
    logic [PIX_W-1:0] o_blended_pixel;
    logic [IDX_W-1:0] o_frame_index;
    logic             o_last_of_run;

    dissolve_scoreboard sb = new();
    bit                 steady;       // no idling on either side while set
    int                 cycle_count;

    pixel_cross_dissolve #(.MAX_FRAMES(MAX_FRAMES)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_frame_count (i_cfg_frame_count),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_first     (i_pixel_first),
        .i_pixel_second    (i_pixel_second),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_blended_pixel   (o_blended_pixel),
        .o_frame_index     (o_frame_index),
        .o_last_of_run     (o_last_of_run)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Observe every transfer at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_blended_pixel, o_frame_index, o_last_of_run);
            if (i_valid && o_ready)
                sb.note_pair(i_pixel_first, i_pixel_second);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_frames(i_cfg_frame_count);
        end
    end

    // Output side: random stall before each result transfer
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Offer one pixel pair after a random gap; returns at its transfer edge
    task automatic send_pair(input logic [PIX_W-1:0] first, input logic [PIX_W-1:0] second);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pixel_first  <= first;
        i_pixel_second <= second;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic end_pairs();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Wait until every predicted result has been seen, then let the block settle
    task automatic drain();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Change the frame count once the block is idle
    task automatic write_frames(input logic [CNT_W-1:0] value);
        drain();
        i_cfg_valid       <= 1'b1;
        i_cfg_frame_count <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly full-range values, with the extremes drawn now and then
    function automatic logic [PIX_W-1:0] draw_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Frame count for a random phase, biased toward the edges and saturation
    function automatic logic [CNT_W-1:0] draw_frames();
        case ($urandom_range(0, 5))
            0:       return 7'd1;
            1:       return 7'd64;
            2:       return 7'd127;
            3:       return 7'($urandom_range(65, 127));
            default: return 7'($urandom_range(1, 63));
        endcase
    endfunction

    // Main sequence
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_frame_count = '0;
        i_valid           = 1'b0;
        i_pixel_first     = '0;
        i_pixel_second    = '0;
        steady            = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame count: extremes and opposite ramps
        send_pair(8'd0,   8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd0,   8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'h55,  8'hAA);
        send_pair(8'hAA,  8'h55);
        end_pairs();

        // Zero frames: pairs vanish without output
        write_frames(7'd0);
        send_pair(8'd0,   8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd17,  8'd200);
        end_pairs();

        // Single frame: only frame index zero, equal to the first pixel
        write_frames(7'd1);
        send_pair(8'd0,   8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd123, 8'd45);
        end_pairs();

        // Longest run
        write_frames(7'd64);
        send_pair(8'd0,   8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd1,   8'd254);
        end_pairs();

        // Counts above the maximum saturate
        write_frames(7'd127);
        send_pair(8'd255, 8'd0);
        send_pair(8'd0,   8'd255);
        end_pairs();
        write_frames(7'd65);
        send_pair(8'd200, 8'd100);
        end_pairs();

        // Random phases, some without any idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_frames((p == 0) ? 7'd2 : draw_frames());
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < RAND_PER_PHASE; k++)
                send_pair(draw_pixel(), draw_pixel());
            end_pairs();
        end
        steady = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/pcd_pkg.sv
sv/pcd_divider.sv
sv/pixel_cross_dissolve.sv
sv/pcd_checker.sv
tb/pixel_cross_dissolve_tb.sv
